### rtl/asfl_pkg.sv
// asfl_pkg: shared types and constants of the actuator safety fault latch
// transaction structs, command codes, register map and parameter defaults
// no dependencies
`default_nettype none
package asfl_pkg;

	localparam int unsigned JOINT_CHANNELS_DFLT = 16;
	localparam int unsigned MOTOR_CHANNELS_DFLT = 16;

	localparam logic [1:0] CMD_JOINT = 2'd0;
	localparam logic [1:0] CMD_MOTOR = 2'd1;
	localparam logic [1:0] CMD_EXTRA = 2'd2;

	localparam logic [1:0] EXCEED_MAX = 2'd3;

	localparam int unsigned CFG_AW = 3;
	localparam logic REG_SAT_LIMIT = 1'b0;
	localparam logic [31:0] SAT_LIMIT_RST = 32'd1000;

	typedef struct packed {
		logic [1:0]          cmd;
		logic [3:0]          channel;
		logic signed [15:0]  sample_value;
		logic [14:0]         channel_limit;
		logic [31:0]         now_ticks;
		logic                safe_flag;
	} asfl_in_t;

	typedef struct packed {
		logic enable;
		logic fault;
	} asfl_out_t;

endpackage
`default_nettype wire

### rtl/asfl_ram.sv
// asfl_ram: generic single-write, single-read RAM with registered read data
// no package dependencies
`default_nettype none
module asfl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### rtl/asfl_cfg.sv
// asfl_cfg: apb register file holding the saturation time limit
// depends on asfl_pkg
`default_nettype none
module asfl_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [asfl_pkg::CFG_AW-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	output logic      [31:0]                  sat_time_limit
);
	import asfl_pkg::*;

	logic        wr_en;
	logic        hit;
	logic [31:0] limit_q;

	assign pready = 1'b1;
	assign hit    = (paddr[CFG_AW-1] == REG_SAT_LIMIT);
	assign wr_en  = psel && penable && pwrite && pready && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= SAT_LIMIT_RST;
		end else if (wr_en) begin
			limit_q <= pwdata;
		end
	end

	assign prdata         = hit ? limit_q : 32'd0;
	assign sat_time_limit = limit_q;

endmodule
`default_nettype wire

### rtl/actuator_safety_fault_latch_top.sv
// Actuator safety fault latch: one sample per cycle in, one transaction out per sample.
// A sample is registered, checked against its channel's state in the following cycle and
// its enable/fault flags land in an output register once that register is free, so
// result_valid comes straight from the output register, and the block sustains one sample
// every cycle while result_ready is held high. The rate rests on the read-modify-write of
// the per-channel exceedance counts and saturation timestamps, which sit in two small RAMs
// read at the accepted sample's channel, or the held one's, with write forwarding.
// Reset clears the fault latch and all channel state; the latch stays set until reset.
// depends on asfl_pkg, asfl_ram, asfl_cfg
`default_nettype none
module actuator_safety_fault_latch_top #(
	parameter int unsigned JOINT_CHANNELS = asfl_pkg::JOINT_CHANNELS_DFLT,
	parameter int unsigned MOTOR_CHANNELS = asfl_pkg::MOTOR_CHANNELS_DFLT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         sample_valid,
	output logic                              sample_ready,
	input  wire asfl_pkg::asfl_in_t           sample,
	output logic                              result_valid,
	input  wire logic                         result_ready,
	output asfl_pkg::asfl_out_t               result,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [asfl_pkg::CFG_AW-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready
);
	import asfl_pkg::*;

	localparam int unsigned JAW = JOINT_CHANNELS > 1 ? $clog2(JOINT_CHANNELS) : 1;
	localparam int unsigned MAW = MOTOR_CHANNELS > 1 ? $clog2(MOTOR_CHANNELS) : 1;

	logic [31:0] sat_time_limit;

	asfl_cfg u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.sat_time_limit (sat_time_limit)
	);

	// input stage
	logic      s1_valid_q;
	asfl_in_t  s1_q;
	logic      adv;
	logic      sample_acc;
	logic      fault_q;
	logic      out_valid_q;
	asfl_out_t out_q;

	assign adv          = s1_valid_q && (!out_valid_q || result_ready);
	assign sample_ready = !s1_valid_q || adv;
	assign sample_acc   = sample_valid && sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (sample_ready) begin
			s1_valid_q <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_acc) begin
			s1_q <= sample;
		end
	end

	// channel addressing
	logic [6:0]     in_ch7;
	logic [6:0]     s1_ch7;
	logic [JAW-1:0] j_raddr;
	logic [JAW-1:0] j_addr;
	logic [MAW-1:0] m_raddr;
	logic [MAW-1:0] m_addr;
	logic           j_inrange;
	logic           m_inrange;

	assign in_ch7    = {3'b000, sample.channel};
	assign s1_ch7    = {3'b000, s1_q.channel};
	assign j_raddr   = sample_ready ? in_ch7[JAW-1:0] : s1_ch7[JAW-1:0];
	assign m_raddr   = sample_ready ? in_ch7[MAW-1:0] : s1_ch7[MAW-1:0];
	assign j_addr    = s1_ch7[JAW-1:0];
	assign m_addr    = s1_ch7[MAW-1:0];
	assign j_inrange = s1_ch7 < 7'(JOINT_CHANNELS);
	assign m_inrange = s1_ch7 < 7'(MOTOR_CHANNELS);

	// exceedance counts
	logic                      j_we;
	logic [1:0]                j_wdata;
	logic [1:0]                j_rdata;
	logic                      j_fwd_q;
	logic [1:0]                j_fwd_data_q;
	logic [JOINT_CHANNELS-1:0] j_vld_q;
	logic [1:0]                j_cnt;

	asfl_ram #(.WIDTH(2), .DEPTH(JOINT_CHANNELS)) u_jnt_ram (
		.clk   (clk),
		.we    (j_we),
		.waddr (j_addr),
		.wdata (j_wdata),
		.raddr (j_raddr),
		.rdata (j_rdata)
	);

	// saturation start times
	logic                      m_we;
	logic [31:0]               m_rdata;
	logic                      m_fwd_q;
	logic [31:0]               m_fwd_data_q;
	logic [MOTOR_CHANNELS-1:0] sat_act_q;
	logic [31:0]               sat_start;
	logic                      sat_act_next;

	asfl_ram #(.WIDTH(32), .DEPTH(MOTOR_CHANNELS)) u_mtr_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_addr),
		.wdata (s1_q.now_ticks),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_fwd_q <= 1'b0;
			m_fwd_q <= 1'b0;
		end else begin
			j_fwd_q <= j_we && (j_addr == j_raddr);
			m_fwd_q <= m_we && (m_addr == m_raddr);
		end
	end

	always_ff @(posedge clk) begin
		j_fwd_data_q <= j_wdata;
		m_fwd_data_q <= s1_q.now_ticks;
	end

	// sample evaluation
	logic [14:0] mag;
	logic [15:0] neg_val;
	logic        over_lim;
	logic        at_lim;
	logic        sat_hold;
	logic [31:0] elapsed;
	logic        fault_set;
	logic        fault_next;
	logic        j_wr;
	logic        m_wr;

	assign neg_val   = 16'(~s1_q.sample_value + 16'sd1);
	assign j_cnt     = !j_vld_q[j_addr] ? 2'd0 : (j_fwd_q ? j_fwd_data_q : j_rdata);
	assign sat_start = m_fwd_q ? m_fwd_data_q : m_rdata;
	assign over_lim  = mag > s1_q.channel_limit;
	assign at_lim    = mag >= s1_q.channel_limit;
	assign sat_hold  = sat_act_q[m_addr] && at_lim;
	assign elapsed   = sat_hold ? (s1_q.now_ticks - sat_start) : 32'd0;

	always_comb begin
		if (s1_q.sample_value == -16'sd32768) begin
			mag = 15'h7fff;
		end else if (s1_q.sample_value[15]) begin
			mag = neg_val[14:0];
		end else begin
			mag = s1_q.sample_value[14:0];
		end
	end

	always_comb begin
		fault_set    = 1'b0;
		j_wr         = 1'b0;
		j_wdata      = 2'd0;
		m_wr         = 1'b0;
		sat_act_next = at_lim;
		case (s1_q.cmd)
			CMD_JOINT: begin
				if (j_inrange) begin
					if (over_lim) begin
						if (!fault_q) begin
							if (j_cnt == EXCEED_MAX) begin
								fault_set = 1'b1;
							end else begin
								j_wr    = 1'b1;
								j_wdata = j_cnt + 2'd1;
							end
						end
					end else begin
						j_wr = 1'b1;
					end
				end
			end
			CMD_MOTOR: begin
				if (m_inrange) begin
					m_wr = !sat_hold;
					if (elapsed >= sat_time_limit) begin
						fault_set = 1'b1;
					end
				end
			end
			CMD_EXTRA: begin
				fault_set = !s1_q.safe_flag;
			end
			default: begin
				fault_set = 1'b0;
			end
		endcase
	end

	assign j_we       = adv && j_wr;
	assign m_we       = adv && m_wr;
	assign fault_next = fault_q || fault_set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q   <= 1'b0;
			j_vld_q   <= '0;
			sat_act_q <= '0;
		end else if (adv) begin
			fault_q <= fault_next;
			if (j_wr) begin
				j_vld_q[j_addr] <= 1'b1;
			end
			if (m_wr) begin
				sat_act_q[m_addr] <= sat_act_next;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.enable <= !fault_next;
			out_q.fault  <= fault_next;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
`default_nettype wire

### dv/actuator_safety_fault_latch_top_test.sv
// actuator_safety_fault_latch_top_test: self-checking bench for the actuator safety fault latch
// drives samples and APB writes, tracks latch state per channel and checks every result flag
// depends on asfl_pkg and actuator_safety_fault_latch_top
`timescale 1ns / 1ps
module actuator_safety_fault_latch_top_test;
	import asfl_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [CFG_AW-1:0] SAT_LIMIT_ADDR = CFG_AW'(4 * REG_SAT_LIMIT);

	class latch_tracker;
		logic [31:0] sat_limit;
		bit latched;
		bit [1:0] exceed_run [JOINT_CHANNELS_DFLT];
		bit sat_on [MOTOR_CHANNELS_DFLT];
		logic [31:0] sat_since [MOTOR_CHANNELS_DFLT];
		asfl_out_t flags_due [$];
		int mismatches;

		function new();
			sat_limit = SAT_LIMIT_RST;
			latched = 1'b0;
			mismatches = 0;
			foreach (exceed_run[i]) exceed_run[i] = '0;
			foreach (sat_on[i]) begin
				sat_on[i] = 1'b0;
				sat_since[i] = '0;
			end
		endfunction

		function void take_sample(asfl_in_t s);
			int mag;
			int c;
			logic [31:0] elapsed;
			asfl_out_t flags;
			mag = int'($signed(s.sample_value));
			if (mag < 0)
				mag = -mag;
			if (mag > 32767)
				mag = 32767;
			c = int'(s.channel);
			case (s.cmd)
				CMD_JOINT: begin
					if (c < JOINT_CHANNELS_DFLT) begin
						if (mag > s.channel_limit) begin
							if (!latched) begin
								if (exceed_run[c] == EXCEED_MAX)
									latched = 1'b1;
								else
									exceed_run[c]++;
							end
						end else begin
							exceed_run[c] = '0;
						end
					end
				end
				CMD_MOTOR: begin
					if (c < MOTOR_CHANNELS_DFLT) begin
						if (!sat_on[c] && mag >= s.channel_limit) begin
							sat_since[c] = s.now_ticks;
							sat_on[c] = 1'b1;
						end else if (mag < s.channel_limit) begin
							sat_since[c] = s.now_ticks;
							sat_on[c] = 1'b0;
						end
						// elapsed wraps, so a clock stepping back reads as a long time
						elapsed = s.now_ticks - sat_since[c];
						if (elapsed >= sat_limit)
							latched = 1'b1;
					end
				end
				CMD_EXTRA: begin
					if (!s.safe_flag)
						latched = 1'b1;
				end
				default: begin
				end
			endcase
			flags.enable = !latched;
			flags.fault = latched;
			flags_due.push_back(flags);
		endfunction

		function void check_flags(asfl_out_t got);
			asfl_out_t want;
			if (flags_due.size() == 0) begin
				$error("unexpected result transaction: enable %0b fault %0b", got.enable,
					got.fault);
				mismatches++;
				return;
			end
			want = flags_due.pop_front();
			if (got.enable !== want.enable) begin
				$error("enable mismatch: expected %0b, actual %0b", want.enable, got.enable);
				mismatches++;
			end
			if (got.fault !== want.fault) begin
				$error("fault mismatch: expected %0b, actual %0b", want.fault, got.fault);
				mismatches++;
			end
		endfunction

		function int pending();
			return flags_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic sample_valid;
	logic sample_ready;
	asfl_in_t sample;
	logic result_valid;
	logic result_ready;
	asfl_out_t result;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	latch_tracker tracker;
	int send_gap_pct;
	int recv_gap_pct;
	bit hold_req;

	always #10 clk = ~clk;

	actuator_safety_fault_latch_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			tracker.check_flags(result);
	end

	function automatic asfl_in_t pack_sample(logic [1:0] cmd, int ch, int val, int lim,
		logic [31:0] now, bit safe);
		asfl_in_t s;
		s.cmd = cmd;
		s.channel = 4'(ch);
		s.sample_value = 16'(val);
		s.channel_limit = 15'(lim);
		s.now_ticks = now;
		s.safe_flag = safe;
		return s;
	endfunction

	// random sample; without may_trip it is steered away from every latch cause
	function automatic asfl_in_t gen_sample(bit may_trip);
		asfl_in_t s;
		int pick;
		int base;
		logic [31:0] span;
		pick = $urandom_range(0, 19);
		s.cmd = pick < 9 ? CMD_JOINT : pick < 17 ? CMD_MOTOR : pick < 19 ? CMD_EXTRA
			: CMD_UNUSED;
		s.channel = $urandom_range(0, 2) != 0 ? 4'($urandom_range(14, 15)) : 4'($urandom);
		case ($urandom_range(0, 7))
			0: s.channel_limit = '0;
			1: s.channel_limit = 15'h7fff;
			2, 3: s.channel_limit = 15'($urandom_range(0, 64));
			default: s.channel_limit = 15'($urandom);
		endcase
		case ($urandom_range(0, 5))
			0: base = int'(s.channel_limit);
			1: base = int'(s.channel_limit) + 1;
			2: base = s.channel_limit > 0 ? int'(s.channel_limit) - 1 : 0;
			3: base = 32768;
			4: base = 32767;
			default: base = $urandom_range(0, 32768);
		endcase
		s.sample_value = 16'($urandom_range(0, 1) ? -base : base);
		s.now_ticks = $urandom;
		s.safe_flag = 1'($urandom_range(0, 1));
		if (s.cmd == CMD_JOINT && !may_trip && !tracker.latched
				&& tracker.exceed_run[s.channel] == EXCEED_MAX)
			s.sample_value = '0;
		if (s.cmd == CMD_MOTOR && tracker.sat_on[s.channel]) begin
			span = tracker.sat_limit;
			if (!may_trip) begin
				if ($urandom_range(0, 3) == 0)
					s.now_ticks = tracker.sat_since[s.channel] + span - 1;
				else
					s.now_ticks = tracker.sat_since[s.channel] + $urandom_range(0, span - 1);
			end else begin
				case ($urandom_range(0, 2))
					0: s.now_ticks = tracker.sat_since[s.channel] + span;
					1: s.now_ticks = tracker.sat_since[s.channel] - 1;
					default: s.now_ticks = $urandom;
				endcase
			end
		end
		if (s.cmd == CMD_EXTRA && !may_trip)
			s.safe_flag = 1'b1;
		return s;
	endfunction

	task automatic send_sample(asfl_in_t s);
		if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (!sample_ready);
		tracker.take_sample(s);
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_sat_limit(logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= SAT_LIMIT_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// read back right after the write
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== value) begin
			$error("sat_time_limit mismatch: expected %0h, actual %0h", value, prdata);
			tracker.mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		tracker.sat_limit = value;
	endtask

	// receiver: random stall bursts and one long hold-off on request
	initial begin
		result_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				result_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if (recv_gap_pct != 0 && $urandom_range(0, 99) < recv_gap_pct) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [31:0] limits [5];
		int send_pct [5];
		int recv_pct [5];
		int trip;
		logic [31:0] t0;
		bit zero_written;
		tracker = new();
		hold_req = 1'b0;
		send_gap_pct = 25;
		recv_gap_pct = 25;
		zero_written = 1'b0;
		arst_n <= 1'b0;
		sample_valid <= 1'b0;
		sample <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed samples at the reset limit, none of them latches
		send_sample(pack_sample(CMD_JOINT, 0, -32768, 32767, 32'h0, 1'b0));
		send_sample(pack_sample(CMD_JOINT, 0, 32767, 32766, 32'hffff_ffff, 1'b1));
		send_sample(pack_sample(CMD_JOINT, 0, -32768, 32766, 32'h0, 1'b0));
		send_sample(pack_sample(CMD_JOINT, 0, -1, 0, 32'h0, 1'b0));
		send_sample(pack_sample(CMD_JOINT, 0, 0, 0, 32'h0, 1'b0));
		send_sample(pack_sample(CMD_JOINT, 15, -5, 4, 32'h0, 1'b1));
		send_sample(pack_sample(CMD_MOTOR, 15, 32767, 32767, 32'hffff_ff00, 1'b0));
		send_sample(pack_sample(CMD_MOTOR, 15, -32768, 32767, 32'h0000_02e7, 1'b0));
		send_sample(pack_sample(CMD_MOTOR, 15, 1, 2, 32'hffff_ffff, 1'b1));
		send_sample(pack_sample(CMD_MOTOR, 0, 0, 0, 32'h0, 1'b0));
		send_sample(pack_sample(CMD_MOTOR, 0, 0, 0, 32'd999, 1'b0));
		send_sample(pack_sample(CMD_EXTRA, 15, -32768, 32767, 32'hffff_ffff, 1'b1));
		send_sample(pack_sample(CMD_UNUSED, 15, -1, 32767, 32'hffff_ffff, 1'b0));
		send_sample(pack_sample(CMD_UNUSED, 0, 0, 0, 32'h0, 1'b1));
		send_sample(pack_sample(CMD_JOINT, 15, 32767, 0, 32'h0, 1'b0));
		drain();

		limits = '{32'd1, 32'hffff_ffff, 32'($urandom_range(2, 5000)), 32'd5, 32'd1000};
		send_pct = '{25, 0, 40, 0, 20};
		recv_pct = '{25, 40, 0, 0, 20};
		for (int p = 0; p < 5; p++) begin
			write_sat_limit(limits[p]);
			send_gap_pct = send_pct[p];
			recv_gap_pct = recv_pct[p];
			for (int n = 0; n < 250; n++) begin
				if (p == 0 && n == 20)
					hold_req = 1'b1;
				send_sample(gen_sample(1'b0));
			end
			drain();
		end

		// one latch cause per run, picked at random
		send_gap_pct = 20;
		recv_gap_pct = 20;
		trip = $urandom_range(0, 4);
		case (trip)
			0: begin
				send_sample(pack_sample(CMD_JOINT, 5, 0, 100, $urandom, 1'b1));
				for (int k = 0; k < 4; k++)
					send_sample(pack_sample(CMD_JOINT, 5, k[0] ? -200 : 200, 100, $urandom,
						1'b1));
			end
			1: begin
				send_sample(pack_sample(CMD_EXTRA, $urandom_range(0, 15), $urandom,
					$urandom, $urandom, 1'b0));
			end
			2: begin
				drain();
				write_sat_limit(32'd0);
				zero_written = 1'b1;
				send_sample(pack_sample(CMD_MOTOR, 3, 0, 32767, $urandom, 1'b1));
			end
			3: begin
				t0 = $urandom;
				send_sample(pack_sample(CMD_MOTOR, 7, 0, 1, t0, 1'b1));
				send_sample(pack_sample(CMD_MOTOR, 7, -32768, 0, t0, 1'b1));
				send_sample(pack_sample(CMD_MOTOR, 7, -32768, 0, t0 - 1, 1'b1));
			end
			default: begin
				while (!tracker.latched)
					send_sample(gen_sample(1'b1));
			end
		endcase
		repeat (20) send_sample(gen_sample(1'b1));
		drain();
		if (!zero_written)
			write_sat_limit(32'd0);

		send_gap_pct = 0;
		recv_gap_pct = 0;
		repeat (100) send_sample(gen_sample(1'b1));
		drain();
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### sim.f
rtl/asfl_pkg.sv
rtl/asfl_ram.sv
rtl/asfl_cfg.sv
rtl/actuator_safety_fault_latch_top.sv
dv/actuator_safety_fault_latch_top_test.sv
